FILE: design/stepper_trapezoid_rate_profile_assert.svh
// assertion macros shared by the checker
`ifndef STEPPER_TRAPEZOID_RATE_PROFILE_ASSERT_SVH
`define STEPPER_TRAPEZOID_RATE_PROFILE_ASSERT_SVH

// condition holds at every edge outside reset
`define STP_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("stp check failed: invariant");

// pre at one edge implies post at the next
`define STP_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("stp check failed: sequence");

// condition holds at the edge after a reset edge
`define STP_ASSERT_AFTER_RESET(label, cond) \
  label: assert property (@(posedge clk) !rst_n |=> (cond)) \
    else $error("stp check failed: reset");

`endif

FILE: design/stp_pkg.sv
package stp_pkg;

  localparam logic [1:0] MODE_PROFILE = 2'd0;
  localparam logic [1:0] MODE_FIXED   = 2'd1;
  localparam logic [1:0] MODE_TICK    = 2'd2;
  localparam logic [1:0] MODE_STOP    = 2'd3;

  localparam logic CFG_RAMP_STEPS  = 1'b0;
  localparam logic CFG_TIMER_CLOCK = 1'b1;

  localparam logic [23:0] RAMP_RESET  = 24'd600;
  localparam logic [31:0] CLOCK_RESET = 32'd84000000;
  localparam logic [31:0] BASE_RESET  = 32'd5500;
  localparam logic [31:0] TOP_RESET   = 32'd11000;
  localparam logic [31:0] RELOAD_MIN  = 32'd2;
  localparam logic [31:0] RELOAD_MAX  = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_PROFILE,
    CMD_FIXED,
    CMD_TICK,
    CMD_STOP
  } cmd_kind_t;

  // classified request, counts and rates already saturated and floored
  typedef struct packed {
    cmd_kind_t   kind;
    logic        fwd;
    logic [31:0] mag;
    logic [31:0] start;
    logic [31:0] peak;
  } cmd_t;

  typedef struct packed {
    logic        we;
    logic        index;
    logic [31:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic        start;
    logic [31:0] rem;
    logic [31:0] word;
    logic [5:0]  iters;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic [31:0] reload_count;
    logic [30:0] compare_count;
    logic [19:0] rate_hz;
    logic        direction;
    logic        moving;
    logic        move_done;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PSEL,
    ST_PMUL,
    ST_PDIV_GO,
    ST_PDIV,
    ST_TDIV_GO,
    ST_TDIV,
    ST_OUT
  } back_state_t;

endpackage

FILE: design/stp_div.sv
module stp_div (
  input  logic               clk,
  input  logic               rst_n,
  input  stp_pkg::div_req_t  req,
  output stp_pkg::div_rsp_t  rsp
);

  logic [31:0] rem_r, rem_nxt;
  logic [31:0] word_r, word_nxt;
  logic [31:0] quot_r, quot_nxt;
  logic [31:0] den_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] trial;
  logic        ge;

  // restoring division, one quotient bit per cycle, remainder kept below the divisor
  always_comb begin
    trial    = {rem_r, word_r[31]};
    ge       = trial >= {1'b0, den_r};
    rem_nxt  = rem_r;
    word_nxt = word_r;
    quot_nxt = quot_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = req.rem;
      word_nxt = req.word;
      quot_nxt = '0;
      cnt_nxt  = req.iters;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = ge ? 32'(trial - {1'b0, den_r}) : trial[31:0];
      word_nxt = {word_r[30:0], 1'b0};
      quot_nxt = {quot_r[30:0], ge};
      cnt_nxt  = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    word_r <= word_nxt;
    quot_r <= quot_nxt;
    if (req.start) begin
      den_r <= req.den;
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

FILE: design/stp_front.sv
module stp_front #(
  parameter int COUNT_BITS = 24,
  parameter int RATE_BITS  = 20
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic [1:0]          in_mode,
  input  logic signed [24:0]  in_step_count,
  input  logic [19:0]         in_start_rate_hz,
  input  logic [19:0]         in_peak_rate_hz,
  input  logic                cmd_pop,
  output logic                cmd_empty,
  output stp_pkg::cmd_t       cmd
);

  localparam logic [32:0] COUNT_MAX = (33'd1 << COUNT_BITS) - 33'd1;
  localparam logic [32:0] RATE_MAX  = (33'd1 << RATE_BITS) - 33'd1;

  logic [24:0]   raw;
  logic [25:0]   mag_full;
  logic [32:0]   mag_w, start_w, peak_w, start_f, peak_f;
  stp_pkg::cmd_t cmd_w;

  stp_pkg::cmd_t slot_r [2];
  logic          wr_ptr_r, rd_ptr_r;
  logic [1:0]    cnt_r;
  logic          push_ok, pop_ok;

  always_comb begin
    raw      = $unsigned(in_step_count);
    mag_full = raw[24] ? (26'h200_0000 - {1'b0, raw}) : {1'b0, raw};
    mag_w    = {7'b0, mag_full};
    if (mag_w > COUNT_MAX) begin
      mag_w = COUNT_MAX;
    end
    start_w = {13'b0, in_start_rate_hz};
    if (start_w > RATE_MAX) begin
      start_w = RATE_MAX;
    end
    peak_w = {13'b0, in_peak_rate_hz};
    if (peak_w > RATE_MAX) begin
      peak_w = RATE_MAX;
    end
    start_f = (start_w == '0) ? 33'd1 : start_w;
    peak_f  = (peak_w < start_f) ? start_f : peak_w;

    cmd_w.fwd   = !raw[24];
    cmd_w.mag   = mag_w[31:0];
    cmd_w.start = start_f[31:0];
    cmd_w.peak  = peak_f[31:0];
    unique case (in_mode)
      stp_pkg::MODE_PROFILE: begin
        cmd_w.kind = (mag_w != '0) ? stp_pkg::CMD_PROFILE : stp_pkg::CMD_NOP;
      end
      stp_pkg::MODE_FIXED: begin
        cmd_w.kind = (mag_w != '0) ? stp_pkg::CMD_FIXED : stp_pkg::CMD_NOP;
      end
      stp_pkg::MODE_TICK: begin
        cmd_w.kind = stp_pkg::CMD_TICK;
      end
      default: begin
        cmd_w.kind = stp_pkg::CMD_STOP;
      end
    endcase
  end

  // two-entry request queue toward the back end
  assign in_full   = (cnt_r == 2'd2);
  assign cmd_empty = (cnt_r == 2'd0);
  assign push_ok   = in_push && !in_full;
  assign pop_ok    = cmd_pop && !cmd_empty;
  assign cmd       = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push_ok) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop_ok) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push_ok && !pop_ok) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop_ok && !push_ok) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      slot_r[wr_ptr_r] <= cmd_w;
    end
  end

endmodule

FILE: design/stp_back.sv
module stp_back #(
  parameter int COUNT_BITS = 24,
  parameter int RATE_BITS  = 20
) (
  input  logic              clk,
  input  logic              rst_n,
  input  stp_pkg::cfg_wr_t  cfg,
  input  logic              cmd_empty,
  input  stp_pkg::cmd_t     cmd,
  output logic              cmd_pop,
  input  logic              out_pop,
  output logic              out_empty,
  output stp_pkg::res_t     out_res
);

  localparam int PROD_W = RATE_BITS + COUNT_BITS;

  stp_pkg::back_state_t state_r, state_nxt;

  logic [23:0]           ramp_r;
  logic [31:0]           clock_r;
  logic [COUNT_BITS-1:0] steps_left_r, steps_taken_r, move_len_r;
  logic [RATE_BITS-1:0]  base_r, top_r, cur_r;
  logic                  running_r, fwd_r, done_r, halt_pend_r;
  logic                  out_valid_r;

  logic [COUNT_BITS-1:0] accel_r, n_r;
  logic [RATE_BITS-1:0]  span_r;
  logic [PROD_W-1:0]     prod_r;
  stp_pkg::res_t         out_r;

  logic [31:0]           ramp32, mlen32, accel32, reload;
  logic [COUNT_BITS-1:0] accel, ramp_down_at, left_dec;
  logic                  cond_up, cond_down, use_top, tick_live, slot_free, load_out;
  logic [RATE_BITS-1:0]  rate_eff, pdiv_rate;
  stp_pkg::div_req_t     div_req;
  stp_pkg::div_rsp_t     div_rsp;
  stp_pkg::res_t         res;

  stp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // profile selection: ramp up, cruise, or ramp down
  always_comb begin
    tick_live    = running_r && (steps_left_r != '0);
    left_dec     = steps_left_r - COUNT_BITS'(1);
    ramp32       = {8'b0, ramp_r};
    mlen32       = 32'(move_len_r);
    accel32      = (ramp32 > mlen32) ? mlen32 : ramp32;
    accel        = accel32[COUNT_BITS-1:0];
    ramp_down_at = move_len_r - accel;
    cond_up      = steps_taken_r < accel;
    cond_down    = (steps_taken_r >= ramp_down_at) && (steps_left_r < accel);
    use_top      = !cond_up && !cond_down;
    pdiv_rate    = base_r + div_rsp.quot[RATE_BITS-1:0];
    rate_eff     = (cur_r == '0) ? RATE_BITS'(1) : cur_r;
    slot_free    = !out_valid_r || out_pop;
  end

  // timer reload from the quotient minus one, floored at RELOAD_MIN, wraps to all ones when the quotient is zero
  always_comb begin
    if (div_rsp.quot == '0) begin
      reload = stp_pkg::RELOAD_MAX;
    end else if (div_rsp.quot < 32'd3) begin
      reload = stp_pkg::RELOAD_MIN;
    end else begin
      reload = div_rsp.quot - 32'd1;
    end
    res.reload_count  = reload;
    res.compare_count = reload[31:1];
    res.rate_hz       = 20'(cur_r);
    res.direction     = fwd_r;
    res.moving        = running_r;
    res.move_done     = done_r;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      stp_pkg::ST_IDLE: begin
        if (!cmd_empty) begin
          if (cmd.kind == stp_pkg::CMD_TICK && tick_live && move_len_r != '0) begin
            state_nxt = stp_pkg::ST_PSEL;
          end else begin
            state_nxt = stp_pkg::ST_TDIV_GO;
          end
        end
      end
      stp_pkg::ST_PSEL:    state_nxt = use_top ? stp_pkg::ST_TDIV_GO : stp_pkg::ST_PMUL;
      stp_pkg::ST_PMUL:    state_nxt = stp_pkg::ST_PDIV_GO;
      stp_pkg::ST_PDIV_GO: state_nxt = stp_pkg::ST_PDIV;
      stp_pkg::ST_PDIV: begin
        if (div_rsp.done) begin
          state_nxt = stp_pkg::ST_TDIV_GO;
        end
      end
      stp_pkg::ST_TDIV_GO: state_nxt = stp_pkg::ST_TDIV;
      stp_pkg::ST_TDIV: begin
        if (div_rsp.done) begin
          state_nxt = stp_pkg::ST_OUT;
        end
      end
      stp_pkg::ST_OUT: begin
        if (slot_free) begin
          state_nxt = stp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = stp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop       = (state_r == stp_pkg::ST_IDLE) && !cmd_empty;
    load_out      = (state_r == stp_pkg::ST_OUT) && slot_free;
    div_req.start = 1'b0;
    div_req.rem   = '0;
    div_req.word  = clock_r;
    div_req.iters = 6'd32;
    div_req.den   = 32'(rate_eff);
    unique case (state_r)
      stp_pkg::ST_PDIV_GO: begin
        // high part is already below the divisor, so only the rate bits remain
        div_req.start = 1'b1;
        div_req.rem   = 32'(prod_r >> RATE_BITS);
        div_req.word  = 32'(prod_r[RATE_BITS-1:0]) << (32 - RATE_BITS);
        div_req.iters = 6'(RATE_BITS);
        div_req.den   = 32'(accel_r);
      end
      stp_pkg::ST_TDIV_GO: begin
        div_req.start = 1'b1;
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= stp_pkg::ST_IDLE;
      ramp_r        <= stp_pkg::RAMP_RESET;
      clock_r       <= stp_pkg::CLOCK_RESET;
      steps_left_r  <= '0;
      steps_taken_r <= '0;
      move_len_r    <= '0;
      base_r        <= RATE_BITS'(stp_pkg::BASE_RESET);
      top_r         <= RATE_BITS'(stp_pkg::TOP_RESET);
      cur_r         <= '0;
      running_r     <= 1'b0;
      fwd_r         <= 1'b1;
      done_r        <= 1'b0;
      halt_pend_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg.we) begin
        case (cfg.index)
          stp_pkg::CFG_RAMP_STEPS:  ramp_r  <= cfg.data[23:0];
          stp_pkg::CFG_TIMER_CLOCK: clock_r <= cfg.data;
          default:                  clock_r <= clock_r;
        endcase
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        stp_pkg::ST_IDLE: begin
          if (cmd_pop) begin
            unique case (cmd.kind)
              stp_pkg::CMD_PROFILE: begin
                fwd_r         <= cmd.fwd;
                move_len_r    <= COUNT_BITS'(cmd.mag);
                steps_left_r  <= COUNT_BITS'(cmd.mag);
                steps_taken_r <= '0;
                base_r        <= RATE_BITS'(cmd.start);
                top_r         <= RATE_BITS'(cmd.peak);
                cur_r         <= RATE_BITS'(cmd.start);
                running_r     <= 1'b1;
                done_r        <= 1'b0;
                halt_pend_r   <= 1'b0;
              end
              stp_pkg::CMD_FIXED: begin
                fwd_r         <= cmd.fwd;
                move_len_r    <= '0;
                steps_left_r  <= COUNT_BITS'(cmd.mag);
                steps_taken_r <= '0;
                cur_r         <= RATE_BITS'(cmd.start);
                running_r     <= 1'b1;
                done_r        <= 1'b0;
                halt_pend_r   <= 1'b0;
              end
              stp_pkg::CMD_TICK: begin
                done_r      <= tick_live && (left_dec == '0);
                // halt waits until the profile rate has been computed
                halt_pend_r <= tick_live && (move_len_r != '0) && (left_dec == '0);
                if (tick_live) begin
                  steps_left_r <= left_dec;
                  if (move_len_r != '0) begin
                    steps_taken_r <= steps_taken_r + COUNT_BITS'(1);
                  end else if (left_dec == '0) begin
                    steps_taken_r <= '0;
                    running_r     <= 1'b0;
                  end
                end
              end
              stp_pkg::CMD_STOP: begin
                done_r        <= running_r;
                halt_pend_r   <= 1'b0;
                steps_left_r  <= '0;
                steps_taken_r <= '0;
                move_len_r    <= '0;
                running_r     <= 1'b0;
              end
              default: begin
                done_r      <= 1'b0;
                halt_pend_r <= 1'b0;
              end
            endcase
          end
        end
        stp_pkg::ST_PSEL: begin
          if (use_top) begin
            cur_r <= top_r;
            if (halt_pend_r) begin
              steps_left_r  <= '0;
              steps_taken_r <= '0;
              move_len_r    <= '0;
              running_r     <= 1'b0;
            end
          end
        end
        stp_pkg::ST_PDIV: begin
          if (div_rsp.done) begin
            cur_r <= pdiv_rate;
            if (halt_pend_r) begin
              steps_left_r  <= '0;
              steps_taken_r <= '0;
              move_len_r    <= '0;
              running_r     <= 1'b0;
            end
          end
        end
        default: begin
          cur_r <= cur_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == stp_pkg::ST_PSEL) begin
      accel_r <= accel;
      n_r     <= cond_up ? steps_taken_r : steps_left_r;
      span_r  <= top_r - base_r;
    end
    if (state_r == stp_pkg::ST_PMUL) begin
      prod_r <= PROD_W'(span_r) * PROD_W'(n_r);
    end
    if (load_out) begin
      out_r <= res;
    end
  end

  assign out_empty = !out_valid_r;
  assign out_res   = out_r;

endmodule

FILE: design/stepper_trapezoid_rate_profile.sv
// Step-rate generator for one stepper axis with a trapezoidal profile.
// Input channel: drive in_mode and the move fields with in_push; a request is
// taken on a clock edge with in_push high and in_full low. A two-entry queue
// holds requests ahead of the rate engine.
// Result channel: while out_empty is low the oldest result sits on the out_
// ports; it is taken on an edge with out_pop high. A held result blocks only
// the next completion, the queue keeps taking requests until it fills.
// Every request gives exactly one result, in order.
// Every request passes through the timer division; a step tick in a running
// profile move first goes through the profile selection, and a tick in a ramp
// also adds a multiply and a ramp division over RATE_BITS quotient bits. The
// engine takes a new request only after the previous one has put its result
// in the output register; the single divider is shared by both divisions.
// Configuration: cfg_we with cfg_index 0 sets ramp_steps, 1 sets
// timer_clock_hz; write only while no request is in flight.
// Reset (rst_n low, synchronous): queue and result emptied, move state cleared,
// start/peak rates 5500/11000, ramp 600 steps, timer clock 84 MHz.
module stepper_trapezoid_rate_profile #(
  parameter int COUNT_BITS = 24,
  parameter int RATE_BITS  = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [1:0]         in_mode,
  input  logic signed [24:0] in_step_count,
  input  logic [19:0]        in_start_rate_hz,
  input  logic [19:0]        in_peak_rate_hz,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [31:0]        out_reload_count,
  output logic [30:0]        out_compare_count,
  output logic [19:0]        out_rate_hz,
  output logic               out_direction,
  output logic               out_moving,
  output logic               out_move_done,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data
);

  stp_pkg::cmd_t    cmd;
  stp_pkg::cfg_wr_t cfg;
  stp_pkg::res_t    res;
  logic             cmd_pop, cmd_empty;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  stp_front #(
    .COUNT_BITS (COUNT_BITS),
    .RATE_BITS  (RATE_BITS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_mode          (in_mode),
    .in_step_count    (in_step_count),
    .in_start_rate_hz (in_start_rate_hz),
    .in_peak_rate_hz  (in_peak_rate_hz),
    .cmd_pop          (cmd_pop),
    .cmd_empty        (cmd_empty),
    .cmd              (cmd)
  );

  stp_back #(
    .COUNT_BITS (COUNT_BITS),
    .RATE_BITS  (RATE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd_empty (cmd_empty),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_res   (res)
  );

  assign out_reload_count  = res.reload_count;
  assign out_compare_count = res.compare_count;
  assign out_rate_hz       = res.rate_hz;
  assign out_direction     = res.direction;
  assign out_moving        = res.moving;
  assign out_move_done     = res.move_done;

endmodule

FILE: design/stp_checker.sv
`include "stepper_trapezoid_rate_profile_assert.svh"

module stp_port_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_empty,
  input logic        out_pop,
  input logic [31:0] out_reload_count,
  input logic [30:0] out_compare_count,
  input logic        out_moving,
  input logic        out_move_done
);

  `STP_ASSERT_AFTER_RESET(a_empty_after_reset, out_empty)
  `STP_ASSERT_NEXT(a_result_held, !out_empty && !out_pop, !out_empty && $stable(out_reload_count) && $stable(out_move_done))
  `STP_ASSERT_ALWAYS(a_compare_half, out_empty || out_compare_count == out_reload_count[31:1])
  `STP_ASSERT_ALWAYS(a_reload_floor, out_empty || out_reload_count >= 32'd2)
  `STP_ASSERT_ALWAYS(a_done_stops, out_empty || !(out_move_done && out_moving))

endmodule

bind stepper_trapezoid_rate_profile stp_port_checker u_stp_port_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_empty         (out_empty),
  .out_pop           (out_pop),
  .out_reload_count  (out_reload_count),
  .out_compare_count (out_compare_count),
  .out_moving        (out_moving),
  .out_move_done     (out_move_done)
);

FILE: test/stp_checker.sv
module stp_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  logic               in_full,
  input  logic [1:0]         in_mode,
  input  logic signed [24:0] in_step_count,
  input  logic [19:0]        in_start_rate_hz,
  input  logic [19:0]        in_peak_rate_hz,
  input  logic               out_empty,
  input  logic               out_pop,
  input  logic [31:0]        out_reload_count,
  input  logic [30:0]        out_compare_count,
  input  logic [19:0]        out_rate_hz,
  input  logic               out_direction,
  input  logic               out_moving,
  input  logic               out_move_done,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 errors,
  output int                 pending,
  output int                 checked
);

  localparam logic [63:0] COUNT_CAP = (64'd1 << 24) - 64'd1;

  logic [23:0] ramp_len;
  logic [31:0] clock_hz;

  logic [23:0] remain_cnt;
  logic [23:0] done_cnt;
  logic [23:0] span_len;
  logic [19:0] floor_hz;
  logic [19:0] cruise_hz;
  logic [19:0] now_hz;
  logic        active;
  logic        fwd_dir;

  stp_pkg::res_t timer_q[$];

  function automatic void clear_move();
    remain_cnt = '0;
    done_cnt   = '0;
    span_len   = '0;
    active     = 1'b0;
  endfunction

  // applies one request to the axis copy and returns the timer setting it yields
  function automatic stp_pkg::res_t advance_axis(logic [1:0] mode, logic [24:0] raw,
                                                 logic [19:0] start_in,
                                                 logic [19:0] peak_in);
    stp_pkg::res_t r;
    logic [63:0]   mag;
    logic [63:0]   start;
    logic [63:0]   peak;
    logic [63:0]   accel;
    logic [63:0]   span;
    logic [63:0]   hz;
    logic [63:0]   q;
    logic [63:0]   reload;
    logic          dir;
    logic          ended;
    ended = 1'b0;
    dir   = !raw[24];
    mag   = raw[24] ? (64'd1 << 25) - 64'(raw) : 64'(raw);
    if (mag > COUNT_CAP) mag = COUNT_CAP;
    start = 64'(start_in);
    peak  = 64'(peak_in);
    case (mode)
      stp_pkg::MODE_PROFILE: if (mag != 64'd0) begin
        if (start == 64'd0) start = 64'd1;
        if (peak < start) peak = start;
        fwd_dir    = dir;
        span_len   = mag[23:0];
        done_cnt   = '0;
        floor_hz   = start[19:0];
        cruise_hz  = peak[19:0];
        remain_cnt = mag[23:0];
        active     = 1'b1;
        now_hz     = start[19:0];
      end
      stp_pkg::MODE_FIXED: if (mag != 64'd0) begin
        fwd_dir    = dir;
        span_len   = '0;
        done_cnt   = '0;
        remain_cnt = mag[23:0];
        active     = 1'b1;
        now_hz     = (start == 64'd0) ? 20'd1 : start[19:0];
      end
      stp_pkg::MODE_TICK: if (active && remain_cnt != '0) begin
        remain_cnt = remain_cnt - 24'd1;
        if (span_len != '0) begin
          done_cnt = done_cnt + 24'd1;
          // ramp length never exceeds the move
          accel = (ramp_len > span_len) ? 64'(span_len) : 64'(ramp_len);
          span  = 64'(cruise_hz) - 64'(floor_hz);
          if (64'(done_cnt) < accel)
            hz = 64'(floor_hz) + span * 64'(done_cnt) / accel;
          else if (64'(done_cnt) >= 64'(span_len) - accel && 64'(remain_cnt) < accel)
            hz = 64'(floor_hz) + span * 64'(remain_cnt) / accel;
          else
            hz = 64'(cruise_hz);
          if (hz < 64'(floor_hz)) hz = 64'(floor_hz);
          now_hz = hz[19:0];
        end
        if (remain_cnt == '0) begin
          clear_move();
          ended = 1'b1;
        end
      end
      stp_pkg::MODE_STOP: begin
        ended = active;
        clear_move();
      end
    endcase

    hz = (now_hz == '0) ? 64'd1 : 64'(now_hz);
    q  = 64'(clock_hz) / hz;
    // clock below the rate wraps to the top of the range
    if (q == 64'd0)
      reload = 64'(stp_pkg::RELOAD_MAX);
    else if (q - 64'd1 < 64'(stp_pkg::RELOAD_MIN))
      reload = 64'(stp_pkg::RELOAD_MIN);
    else
      reload = q - 64'd1;

    r.reload_count  = reload[31:0];
    r.compare_count = reload[31:1];
    r.rate_hz       = now_hz;
    r.direction     = fwd_dir;
    r.moving        = active;
    r.move_done     = ended;
    return r;
  endfunction

  task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (errors < 40)
      $display("mismatch on result %0d: %s got %0d want %0d", checked, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin : watch
    stp_pkg::res_t want;
    if (!rst_n) begin
      ramp_len  = stp_pkg::RAMP_RESET;
      clock_hz  = stp_pkg::CLOCK_RESET;
      clear_move();
      floor_hz  = stp_pkg::BASE_RESET[19:0];
      cruise_hz = stp_pkg::TOP_RESET[19:0];
      now_hz    = '0;
      fwd_dir   = 1'b1;
      timer_q.delete();
      errors    = 0;
      checked   = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == stp_pkg::CFG_RAMP_STEPS)
          ramp_len = cfg_data[23:0];
        else
          clock_hz = cfg_data;
      end
      if (in_push && !in_full)
        timer_q.push_back(advance_axis(in_mode, in_step_count,
                                       in_start_rate_hz, in_peak_rate_hz));
      if (out_pop && !out_empty) begin
        if (timer_q.size() == 0) begin
          flag_mismatch("result with no request waiting, reload",
                        64'(out_reload_count), 64'd0);
        end else begin
          want = timer_q.pop_front();
          if (out_reload_count !== want.reload_count)
            flag_mismatch("reload_count", 64'(out_reload_count), 64'(want.reload_count));
          if (out_compare_count !== want.compare_count)
            flag_mismatch("compare_count", 64'(out_compare_count),
                          64'(want.compare_count));
          if (out_rate_hz !== want.rate_hz)
            flag_mismatch("rate_hz", 64'(out_rate_hz), 64'(want.rate_hz));
          if (out_direction !== want.direction)
            flag_mismatch("direction", 64'(out_direction), 64'(want.direction));
          if (out_moving !== want.moving)
            flag_mismatch("moving", 64'(out_moving), 64'(want.moving));
          if (out_move_done !== want.move_done)
            flag_mismatch("move_done", 64'(out_move_done), 64'(want.move_done));
          checked++;
        end
      end
    end
    pending = timer_q.size();
  end

endmodule

FILE: test/tb_stepper_trapezoid_rate_profile.sv
module tb_stepper_trapezoid_rate_profile;

  logic               clk              = 1'b0;
  logic               rst_n            = 1'b0;
  logic               in_push          = 1'b0;
  logic               in_full;
  logic [1:0]         in_mode          = stp_pkg::MODE_TICK;
  logic signed [24:0] in_step_count    = '0;
  logic [19:0]        in_start_rate_hz = '0;
  logic [19:0]        in_peak_rate_hz  = '0;
  logic               out_empty;
  logic               out_pop          = 1'b0;
  logic [31:0]        out_reload_count;
  logic [30:0]        out_compare_count;
  logic [19:0]        out_rate_hz;
  logic               out_direction;
  logic               out_moving;
  logic               out_move_done;
  logic               cfg_we           = 1'b0;
  logic               cfg_index        = stp_pkg::CFG_RAMP_STEPS;
  logic [31:0]        cfg_data         = '0;

  int errors;
  int pending;
  int checked;

  int requests_sent  = 0;
  int moved          = 0;
  int settings_used  = 0;
  bit send_calm      = 1'b0;
  bit pop_calm       = 1'b0;

  logic [23:0] ramp_plan [6];
  logic [31:0] clock_plan [6];

  stepper_trapezoid_rate_profile uut (.*);

  stp_checker rate_check (.*);

  always #1 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 20);
    return $urandom_range(50, 300);
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_req(logic [1:0] mode, logic signed [24:0] cnt,
                          logic [19:0] first_hz, logic [19:0] peak_hz);
    int gap;
    gap = (send_calm || $urandom_range(0, 3) != 0) ? 0 : pick_gap();
    if (gap != 0) begin
      in_push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_push          = 1'b1;
    in_mode          = mode;
    in_step_count    = cnt;
    in_start_rate_hz = first_hz;
    in_peak_rate_hz  = peak_hz;
    while (in_full) @(negedge clk);
    @(negedge clk);
    requests_sent++;
  endtask

  // waits for every result, lets the engine settle, then writes both registers
  task automatic load_profile_regs(logic [23:0] ramp, logic [31:0] clock_hz);
    in_push = 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (70) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = stp_pkg::CFG_RAMP_STEPS;
    cfg_data  = {8'd0, ramp};
    @(negedge clk);
    cfg_index = stp_pkg::CFG_TIMER_CLOCK;
    cfg_data  = clock_hz;
    @(negedge clk);
    cfg_we = 1'b0;
    settings_used++;
  endtask

  // one move request followed by its step ticks, sometimes cut short
  task automatic run_move();
    logic signed [24:0] cnt;
    logic [19:0]        lo;
    logic [19:0]        hi;
    logic [1:0]         kind;
    int                 len;
    int                 ticks;
    int                 first;
    first     = requests_sent;
    send_calm = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 9) == 0)
      len = $urandom_range(41, 16777215);
    else
      len = $urandom_range(1, 40);
    cnt = ($urandom_range(0, 1) != 0) ? 25'(-len) : 25'(len);
    case ($urandom_range(0, 3))
      0: begin
        lo = 20'($urandom);
        hi = 20'($urandom);
      end
      1: begin
        lo = 20'($urandom_range(0, 50));
        hi = 20'($urandom_range(0, 200));
      end
      default: begin
        lo = 20'($urandom_range(1, 20000));
        hi = 20'(32'(lo) + $urandom_range(0, 60000));
      end
    endcase
    kind = ($urandom_range(0, 4) == 0) ? stp_pkg::MODE_FIXED : stp_pkg::MODE_PROFILE;
    send_req(kind, cnt, lo, hi);
    if (len <= 40 && $urandom_range(0, 4) != 0)
      ticks = len;
    else
      ticks = $urandom_range(0, (len > 40) ? 40 : len - 1);
    repeat (ticks)
      send_req(stp_pkg::MODE_TICK, 25'($urandom), 20'($urandom), 20'($urandom));
    if (ticks < len && $urandom_range(0, 1) != 0)
      send_req(stp_pkg::MODE_STOP, 25'($urandom), 20'($urandom), 20'($urandom));
    moved += requests_sent - first;
  endtask

  initial begin : pop_side
    int stall;
    stall = 0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 299) == 0) pop_calm = !pop_calm;
      if (stall != 0) begin
        out_pop = 1'b0;
        stall--;
      end else begin
        out_pop = 1'b1;
        if (!pop_calm && $urandom_range(0, 5) == 0) stall = pick_gap();
      end
    end
  end

  initial begin : stimulus
    int ph;
    int target;
    int w;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // reset settings: idle outputs, ignored requests, floors, restarts, stops
    send_req(stp_pkg::MODE_TICK, '0, '0, '0);
    send_req(stp_pkg::MODE_STOP, '0, '0, '0);
    send_req(stp_pkg::MODE_PROFILE, '0, 20'd100, 20'd200);
    send_req(stp_pkg::MODE_FIXED, '0, 20'd100, 20'd200);
    send_req(stp_pkg::MODE_PROFILE, 25'sd5, '0, '0);
    send_req(stp_pkg::MODE_TICK, '0, '0, '0);
    send_req(stp_pkg::MODE_TICK, '0, '0, '0);
    // most negative count saturates, replaces the running move
    send_req(stp_pkg::MODE_PROFILE, 25'h1000000, 20'hFFFFF, 20'hFFFFF);
    send_req(stp_pkg::MODE_TICK, '0, '0, '0);
    send_req(stp_pkg::MODE_STOP, '0, '0, '0);
    send_req(stp_pkg::MODE_FIXED, 25'h0FFFFFF, '0, 20'hFFFFF);
    send_req(stp_pkg::MODE_TICK, '0, '0, '0);
    send_req(stp_pkg::MODE_FIXED, 25'h1000001, 20'hFFFFF, '0);
    send_req(stp_pkg::MODE_STOP, '0, '0, '0);
    // peak below start, move ends by count
    send_req(stp_pkg::MODE_PROFILE, 25'sd3, 20'd1000, 20'd500);
    repeat (3) send_req(stp_pkg::MODE_TICK, '0, '0, '0);

    // no ramp: straight to peak
    load_profile_regs(24'd0, stp_pkg::CLOCK_RESET);
    send_req(stp_pkg::MODE_PROFILE, 25'sd4, 20'd100, 20'd2000);
    repeat (4) send_req(stp_pkg::MODE_TICK, '0, '0, '0);

    // timer clock at, below and a little above the rate
    load_profile_regs(stp_pkg::RAMP_RESET, 32'd1);
    send_req(stp_pkg::MODE_FIXED, 25'sd2, 20'd1, '0);
    send_req(stp_pkg::MODE_FIXED, 25'sd2, 20'd5, '0);
    load_profile_regs(stp_pkg::RAMP_RESET, 32'd10);
    send_req(stp_pkg::MODE_FIXED, 25'sd1, 20'd3, '0);

    ramp_plan[0]  = stp_pkg::RAMP_RESET;
    clock_plan[0] = stp_pkg::CLOCK_RESET;
    ramp_plan[1]  = 24'd0;
    clock_plan[1] = stp_pkg::RELOAD_MAX;
    ramp_plan[2]  = 24'd3;
    clock_plan[2] = 32'd1;
    ramp_plan[3]  = 24'hFFFFFF;
    clock_plan[3] = stp_pkg::CLOCK_RESET;
    ramp_plan[4]  = 24'd1;
    clock_plan[4] = $urandom_range(1, 1000);
    ramp_plan[5]  = 24'($urandom_range(2, 40));
    clock_plan[5] = $urandom_range(1, 32'hFFFFFFFF);

    for (ph = 0; ph < 6; ph++) begin
      load_profile_regs(ramp_plan[ph], clock_plan[ph]);
      target = moved + 150;
      while (moved < target) begin
        if ($urandom_range(0, 9) == 0) begin
          send_calm = 1'b0;
          send_req(2'($urandom_range(stp_pkg::MODE_PROFILE, stp_pkg::MODE_STOP)),
                   25'($urandom), 20'($urandom), 20'($urandom));
        end else begin
          run_move();
        end
      end
    end

    in_push = 1'b0;
    for (w = 0; w < 200000 && pending != 0; w++) @(negedge clk);
    repeat (70) @(negedge clk);

    $display("covered %0d requests (%0d in move sequences) over %0d register settings",
             requests_sent, moved, settings_used);
    $display("%0d results compared, %0d mismatches, %0d still waiting",
             checked, errors, pending);
    if (errors == 0 && pending == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin : watchdog
    #6000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
